// ===== rtl/core/mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types and constants for the MQTT field serializer.
// ----------------------------------------------------------------------------
package mfs_pkg;

  // Step kinds carried on the func field
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_U16  = 2'd1,
    KIND_U32  = 2'd2,
    KIND_VBI  = 2'd3
  } kind_e;

  // Variable byte integer size limits
  localparam logic [31:0] VBI_LIM1 = 32'd128;
  localparam logic [31:0] VBI_LIM2 = 32'd16384;
  localparam logic [31:0] VBI_LIM3 = 32'd2097152;
  localparam logic [31:0] VBI_MAX  = 32'd268435455;

  localparam int unsigned MAX_BYTES = 4;

  // Fully encoded step: bytes in wire order, run length, range error
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      err;
  } enc_t;

endpackage

// ===== rtl/core/mfs_if.sv =====
// ----------------------------------------------------------------------------
// mfs_if
// Valid/ready channels for encoding steps and serialized result bytes.
// ----------------------------------------------------------------------------
interface mfs_step_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface mfs_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] byte_count;
  logic       last;
  logic       range_error;

  modport source (output valid, output out_byte, output byte_count,
                  output last, output range_error, input ready);
  modport sink   (input valid, input out_byte, input byte_count,
                  input last, input range_error, output ready);
endinterface

// ===== rtl/core/mfs_encoder.sv =====
// ----------------------------------------------------------------------------
// mfs_encoder
// Combinational encoder: turns one step kind and value into its wire bytes.
// ----------------------------------------------------------------------------
module mfs_encoder (
  input  logic [1:0]     func_i,
  input  logic [31:0]    value_i,
  output mfs_pkg::enc_t  enc_o
);

  logic [2:0] vbi_n;

  // Variable integer length from the value magnitude
  always_comb begin
    if (value_i < mfs_pkg::VBI_LIM1) begin
      vbi_n = 3'd1;
    end else if (value_i < mfs_pkg::VBI_LIM2) begin
      vbi_n = 3'd2;
    end else if (value_i < mfs_pkg::VBI_LIM3) begin
      vbi_n = 3'd3;
    end else begin
      vbi_n = 3'd4;
    end
  end

  // Byte selection per kind, bytes held in wire order
  always_comb begin
    enc_o = '0;
    case (mfs_pkg::kind_e'(func_i))
      mfs_pkg::KIND_BYTE: begin
        enc_o.bytes[0] = value_i[7:0];
        enc_o.count    = 3'd1;
      end
      mfs_pkg::KIND_U16: begin
        enc_o.bytes[0] = value_i[15:8];
        enc_o.bytes[1] = value_i[7:0];
        enc_o.count    = 3'd2;
      end
      mfs_pkg::KIND_U32: begin
        enc_o.bytes[0] = value_i[31:24];
        enc_o.bytes[1] = value_i[23:16];
        enc_o.bytes[2] = value_i[15:8];
        enc_o.bytes[3] = value_i[7:0];
        enc_o.count    = 3'd4;
      end
      mfs_pkg::KIND_VBI: begin
        if (value_i > mfs_pkg::VBI_MAX) begin
          // out of range: single zero byte with error flag
          enc_o.count = 3'd1;
          enc_o.err   = 1'b1;
        end else begin
          // 7-bit groups, low group first, continuation bit on all but last
          enc_o.bytes[0] = {(vbi_n > 3'd1), value_i[6:0]};
          enc_o.bytes[1] = {(vbi_n > 3'd2), value_i[13:7]};
          enc_o.bytes[2] = {(vbi_n > 3'd3), value_i[20:14]};
          enc_o.bytes[3] = {1'b0, value_i[27:21]};
          enc_o.count    = vbi_n;
        end
      end
      default: begin
        enc_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/mfs_emitter.sv =====
// ----------------------------------------------------------------------------
// mfs_emitter
// Result register: holds one encoded step and sends its bytes one per cycle while result_o.ready is high.
// ----------------------------------------------------------------------------
module mfs_emitter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 enc_valid_i,
  input  mfs_pkg::enc_t        enc_i,
  output logic                 load_o,
  mfs_result_if.source         result_o
);

  logic                                  valid_q, valid_d;
  mfs_pkg::enc_t                         enc_q;
  logic [$clog2(mfs_pkg::MAX_BYTES)-1:0] idx_q, idx_d;
  logic                                  last;
  logic                                  xfer;

  // Position tracking within the run
  assign last = ({1'b0, idx_q} + 3'd1) == enc_q.count;
  assign xfer = valid_q && result_o.ready;

  // Load a new step when empty or as the final byte transfers
  assign load_o = enc_valid_i && (!valid_q || (xfer && last));

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_o) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (xfer) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_o) begin
      enc_q <= enc_i;
    end
  end

  // Result channel
  assign result_o.valid       = valid_q;
  assign result_o.out_byte    = enc_q.bytes[idx_q];
  assign result_o.byte_count  = enc_q.count;
  assign result_o.last        = last;
  assign result_o.range_error = enc_q.err;

endmodule

// ===== rtl/core/mqtt_field_serializer_top.sv =====
// ----------------------------------------------------------------------------
// mqtt_field_serializer_top
// MQTT field serializer: one encoding step in, its wire bytes out.
// ----------------------------------------------------------------------------
//  Channel   | Dir | Payload                                     | Role
//  ----------+-----+---------------------------------------------+-------------
//  step_i    | in  | func[1:0], value[31:0]                      | one step
//  result_o  | out | out_byte, byte_count, last, range_error     | one per byte
//
// A step is latched in the input register, encoded in one combinational pass
// and loaded into the result register, which sends one byte per cycle while
// result_o.ready is high. A step therefore yields 1 to 4 bytes (kind and
// value dependent); the sustained rate is set by the single-byte result port.
// The next step is taken while the current run is still sending; it loads
// on the cycle the final byte transfers, so runs go out back to back.
// Reset clears the valid flags and the byte index only; output stalls back
// up into step_i.ready.
// ----------------------------------------------------------------------------
module mqtt_field_serializer_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  mfs_step_if.sink     step_i,
  mfs_result_if.source result_o
);

  logic          in_valid_q;
  logic [1:0]    func_q;
  logic [31:0]   value_q;
  mfs_pkg::enc_t enc;
  logic          load;

  // Input register frees as soon as its step moves to the result register
  assign step_i.ready = !in_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (step_i.ready) begin
      in_valid_q <= step_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.valid && step_i.ready) begin
      func_q  <= step_i.func;
      value_q <= step_i.value;
    end
  end

  // Encode
  mfs_encoder u_encoder (
    .func_i  (func_q),
    .value_i (value_q),
    .enc_o   (enc)
  );

  // Emit
  mfs_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enc_valid_i (in_valid_q),
    .enc_i       (enc),
    .load_o      (load),
    .result_o    (result_o)
  );

endmodule
